// ===== hw/rtl/mrsd_pkg.sv =====
package mrsd_pkg;

    localparam int NUM_BRANCHES = 4;
    localparam int FRAC_BITS    = 16;
    localparam int VAL_BITS     = FRAC_BITS + 4;
    localparam int PROD_BITS    = 2 * VAL_BITS;
    localparam int RUN_BITS     = 6;
    localparam int STEP_BITS    = 10;

    localparam logic [VAL_BITS-1:0] ONE_VAL = VAL_BITS'(1) << FRAC_BITS;
    localparam logic [VAL_BITS-1:0] VAL_MAX = '1;

    localparam logic [1:0] CMD_PLAN  = 2'd0;
    localparam logic [1:0] CMD_RESID = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] CFG_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_WARMUP    = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;
    localparam logic [1:0] CFG_MAX_RUN   = 2'd3;

    typedef struct packed {
        logic [VAL_BITS-1:0] ratio;
        logic [VAL_BITS-1:0] error;
        logic [RUN_BITS-1:0] run;
        logic                resid;
    } branch_rec_t;

    typedef struct packed {
        logic                 enable;
        logic [STEP_BITS-1:0] warmup;
        logic [VAL_BITS-1:0]  threshold;
        logic [RUN_BITS-1:0]  max_run;
    } mrsd_cfg_t;

    localparam branch_rec_t REC_RESET = '{
        ratio: ONE_VAL,
        error: '0,
        run:   '0,
        resid: 1'b0
    };

endpackage

// ===== hw/rtl/mrsd_decide.sv =====
module mrsd_decide
    import mrsd_pkg::*;
(
    input  mrsd_cfg_t             cfg,
    input  logic [1:0]            cmd,
    input  logic [STEP_BITS-1:0]  step_num,
    input  logic [VAL_BITS-1:0]   step_ratio,
    input  branch_rec_t           rec,
    output branch_rec_t           rec_next,
    output logic                  skip
);

    logic [PROD_BITS-1:0] prod;
    logic [PROD_BITS-1:0] rounded;
    logic [VAL_BITS-1:0]  ratio_new;
    logic [VAL_BITS-1:0]  dev;
    logic [VAL_BITS:0]    err_sum;
    logic [VAL_BITS-1:0]  err_new;
    logic [RUN_BITS:0]    steps;
    logic                 eligible;
    logic                 accept_skip;

    assign prod    = PROD_BITS'(rec.ratio) * PROD_BITS'(step_ratio);
    // round half up, then drop the fraction
    assign rounded = (prod + (PROD_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign ratio_new = (|rounded[PROD_BITS-1:VAL_BITS]) ? VAL_MAX
                                                       : rounded[VAL_BITS-1:0];

    assign dev = (ratio_new >= ONE_VAL) ? (ratio_new - ONE_VAL) : (ONE_VAL - ratio_new);
    assign err_sum = {1'b0, rec.error} + {1'b0, dev};
    assign err_new = err_sum[VAL_BITS] ? VAL_MAX : err_sum[VAL_BITS-1:0];
    assign steps   = {1'b0, rec.run} + (RUN_BITS+1)'(1);

    assign eligible    = cfg.enable && (step_num >= cfg.warmup) && rec.resid;
    assign accept_skip = (err_new <= cfg.threshold) && (steps <= {1'b0, cfg.max_run});

    always_comb
    begin
        rec_next = rec;
        skip     = 1'b0;
        case (cmd)
            CMD_PLAN:
            begin
                if (eligible)
                begin
                    if (accept_skip)
                    begin
                        rec_next.ratio = ratio_new;
                        rec_next.error = err_new;
                        rec_next.run   = steps[RUN_BITS-1:0];
                        skip           = 1'b1;
                    end
                    else
                    begin
                        rec_next.ratio = ONE_VAL;
                        rec_next.error = '0;
                        rec_next.run   = '0;
                    end
                end
            end
            CMD_RESID:
            begin
                if (cfg.enable)
                    rec_next.resid = 1'b1;
            end
            default:
            begin
                rec_next = rec;
            end
        endcase
    end

endmodule

// ===== hw/rtl/magnitude_ratio_skip_decider.sv =====
// Skip decider for cached denoising steps, one record per conditioning branch.
// Input channel: drive cmd, branch_id, step_num and step_ratio with start;
// a beat is taken at each rising edge with start high and busy low. busy stays
// low, so a beat may be issued in every cycle.
// Commands: plan step (decide skip or full compute), residual captured for a
// branch, clear all branches. Unused command codes and out-of-range branches
// leave the records alone and answer skip 0, run_length 0.
// Result channel: done is high for exactly one cycle with skip and run_length;
// an accepted beat goes through the input register, then the result register.
// Every input beat gives one result beat; the receiver cannot stall.
// Throughput: one item per cycle. Between the input register and the result
// register the branch record is read and updated combinationally (multiply,
// round, absolute deviation, add, compare) and written back with the result.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while no beat is in flight.
// Reset: config and result registers zero (input data registers not reset);
// every branch at ratio 1.0, error 0, run 0, no residual; no result pending.
module magnitude_ratio_skip_decider
    import mrsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           cmd,
    input  logic [1:0]           branch_id,
    input  logic [STEP_BITS-1:0] step_num,
    input  logic [VAL_BITS-1:0]  step_ratio,
    output logic                 done,
    output logic                 skip,
    output logic [RUN_BITS-1:0]  run_length,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [VAL_BITS-1:0]  cfg_data
);

    mrsd_cfg_t             cfg_reg;
    branch_rec_t           tbl_reg [NUM_BRANCHES];

    logic                  in_valid_reg;
    logic [1:0]            cmd_reg;
    logic [1:0]            branch_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [VAL_BITS-1:0]   ratio_reg;

    logic                  done_reg;
    logic                  skip_reg;
    logic [RUN_BITS-1:0]   run_reg;

    logic                  branch_ok;
    logic                  cmd_ok;
    branch_rec_t           rec_cur;
    branch_rec_t           rec_new;
    logic                  dec_skip;
    logic                  skip_next;
    logic [RUN_BITS-1:0]   run_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign branch_ok = int'(branch_reg) < NUM_BRANCHES;
    assign cmd_ok    = (cmd_reg == CMD_PLAN) || (cmd_reg == CMD_RESID);
    assign rec_cur   = branch_ok ? tbl_reg[branch_reg] : REC_RESET;

    mrsd_decide u_decide (
        .cfg        (cfg_reg),
        .cmd        (cmd_reg),
        .step_num   (step_reg),
        .step_ratio (ratio_reg),
        .rec        (rec_cur),
        .rec_next   (rec_new),
        .skip       (dec_skip)
    );

    assign skip_next = cmd_ok && branch_ok && dec_skip;
    assign run_next  = (cmd_ok && branch_ok) ? rec_new.run : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENABLE:    cfg_reg.enable    <= cfg_data[0];
                CFG_WARMUP:    cfg_reg.warmup    <= cfg_data[STEP_BITS-1:0];
                CFG_THRESHOLD: cfg_reg.threshold <= cfg_data;
                CFG_MAX_RUN:   cfg_reg.max_run   <= cfg_data[RUN_BITS-1:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // capture the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg    <= cmd;
            branch_reg <= branch_id;
            step_reg   <= step_num;
            ratio_reg  <= step_ratio;
        end
    end

    // branch records: write back the updated record, or clear all
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BRANCHES; b++)
                tbl_reg[b] <= REC_RESET;
        end
        else if (in_valid_reg)
        begin
            if (cmd_reg == CMD_CLEAR)
            begin
                for (int b = 0; b < NUM_BRANCHES; b++)
                    tbl_reg[b] <= REC_RESET;
            end
            else if (cmd_ok && branch_ok)
            begin
                tbl_reg[branch_reg] <= rec_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            skip_reg <= 1'b0;
            run_reg  <= '0;
        end
        else
        begin
            done_reg <= in_valid_reg;
            skip_reg <= in_valid_reg && skip_next;
            run_reg  <= run_next;
        end
    end

    assign done       = done_reg;
    assign skip       = skip_reg;
    assign run_length = run_reg;

`ifndef SYNTH
    a_skip_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> done_reg)
        else $error("skip without result strobe");

    a_skip_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && skip_reg |-> (run_reg != '0) && (run_reg <= cfg_reg.max_run))
        else $error("skip with run length out of range");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && (cmd_reg == CMD_CLEAR) |=> done_reg && !skip_reg && (run_reg == '0))
        else $error("clear gave a nonzero result");

    a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |=> done_reg)
        else $error("input beat lost");

    a_skip_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !cfg_reg.enable |=> !skip_reg)
        else $error("skip while disabled");
`endif

endmodule

// ===== tb/magnitude_ratio_skip_decider_tb.sv =====
`timescale 1ns / 100ps

module magnitude_ratio_skip_decider_tb;
    import mrsd_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         NUM_PHASES  = 8;
    localparam int         PHASE_ITEMS = 250;

    typedef struct packed {
        logic                skip;
        logic [RUN_BITS-1:0] run;
    } decision_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           cmd;
    logic [1:0]           branch_id;
    logic [STEP_BITS-1:0] step_num;
    logic [VAL_BITS-1:0]  step_ratio;
    logic                 done;
    logic                 skip;
    logic [RUN_BITS-1:0]  run_length;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [VAL_BITS-1:0]  cfg_data;

    // Shadow copy of the registers and the branch table
    logic                 cfg_enable;
    logic [STEP_BITS-1:0] cfg_warmup;
    logic [VAL_BITS-1:0]  cfg_threshold;
    logic [RUN_BITS-1:0]  cfg_max_run;
    logic [VAL_BITS-1:0]  tbl_ratio [NUM_BRANCHES];
    logic [VAL_BITS-1:0]  tbl_error [NUM_BRANCHES];
    logic [RUN_BITS-1:0]  tbl_run   [NUM_BRANCHES];
    logic                 tbl_resid [NUM_BRANCHES];

    decision_t            pending_decisions [$];
    int                   mismatch_count;
    int                   cycle_count;
    bit                   sender_gaps;
    logic [STEP_BITS-1:0] step_ctr [NUM_BRANCHES];

    magnitude_ratio_skip_decider dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .branch_id  (branch_id),
        .step_num   (step_num),
        .step_ratio (step_ratio),
        .done       (done),
        .skip       (skip),
        .run_length (run_length),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void clear_table();
        for (int b = 0; b < NUM_BRANCHES; b++)
        begin
            tbl_ratio[b] = ONE_VAL;
            tbl_error[b] = '0;
            tbl_run[b]   = '0;
            tbl_resid[b] = 1'b0;
        end
    endfunction

    function automatic decision_t decide_item(input logic [1:0] op, input logic [1:0] b,
                                              input logic [STEP_BITS-1:0] s,
                                              input logic [VAL_BITS-1:0] r);
        decision_t           d;
        logic [PROD_BITS:0]  prod;
        logic [VAL_BITS-1:0] new_ratio;
        logic [VAL_BITS-1:0] dev;
        logic [VAL_BITS:0]   err_sum;
        logic [VAL_BITS-1:0] new_err;
        logic [RUN_BITS:0]   steps;
        d.skip = 1'b0;
        d.run  = '0;
        if (op == CMD_CLEAR)
        begin
            clear_table();
        end
        else if (op == CMD_RESID)
        begin
            if (cfg_enable)
                tbl_resid[b] = 1'b1;
            d.run = tbl_run[b];
        end
        else if (op == CMD_PLAN)
        begin
            if (cfg_enable && s >= cfg_warmup && tbl_resid[b])
            begin
                // round half up, then saturate
                prod = (PROD_BITS+1)'(tbl_ratio[b]) * (PROD_BITS+1)'(r)
                       + (PROD_BITS+1)'(ONE_VAL >> 1);
                prod = prod >> FRAC_BITS;
                new_ratio = (prod > VAL_MAX) ? VAL_MAX : prod[VAL_BITS-1:0];
                dev = (new_ratio >= ONE_VAL) ? new_ratio - ONE_VAL : ONE_VAL - new_ratio;
                err_sum = {1'b0, tbl_error[b]} + {1'b0, dev};
                new_err = (err_sum > VAL_MAX) ? VAL_MAX : err_sum[VAL_BITS-1:0];
                steps = {1'b0, tbl_run[b]} + (RUN_BITS+1)'(1);
                if (new_err <= cfg_threshold && steps <= cfg_max_run)
                begin
                    tbl_ratio[b] = new_ratio;
                    tbl_error[b] = new_err;
                    tbl_run[b]   = steps[RUN_BITS-1:0];
                    d.skip       = 1'b1;
                end
                else
                begin
                    tbl_ratio[b] = ONE_VAL;
                    tbl_error[b] = '0;
                    tbl_run[b]   = '0;
                end
            end
            d.run = tbl_run[b];
        end
        return d;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [1:0] b,
                             input logic [STEP_BITS-1:0] s, input logic [VAL_BITS-1:0] r);
        int gap;
        int roll;
        start      <= 1'b1;
        cmd        <= op;
        branch_id  <= b;
        step_num   <= s;
        step_ratio <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_decisions.push_back(decide_item(op, b, s, r));
        gap = 0;
        if (sender_gaps)
        begin
            roll = $urandom_range(0, 99);
            if (roll >= 95)
                gap = $urandom_range(5, 30);
            else if (roll >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off until every issued beat has produced its result
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [VAL_BITS-1:0] value);
        logic [VAL_BITS-1:0] mask;
        logic [VAL_BITS-1:0] data;
        wait_idle();
        case (idx)
            CFG_ENABLE:    mask = VAL_BITS'(1);
            CFG_WARMUP:    mask = VAL_BITS'((1 << STEP_BITS) - 1);
            CFG_THRESHOLD: mask = VAL_MAX;
            default:       mask = VAL_BITS'((1 << RUN_BITS) - 1);
        endcase
        // bits above the register width must be dropped by the block
        data = value & mask;
        if ($urandom_range(0, 1) == 1)
            data = data | (VAL_BITS'($urandom) & ~mask);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ENABLE:    cfg_enable    = data[0];
            CFG_WARMUP:    cfg_warmup    = data[STEP_BITS-1:0];
            CFG_THRESHOLD: cfg_threshold = data;
            default:       cfg_max_run   = data[RUN_BITS-1:0];
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic test_disabled();
        send_item(CMD_RESID, 2'd0, '0, '0);
        send_item(CMD_PLAN, 2'd0, '1, VAL_MAX);
        send_item(CMD_UNUSED, 2'd3, '1, VAL_MAX);
        send_item(CMD_CLEAR, 2'd1, '0, '0);
    endtask

    task automatic test_skip_path();
        write_reg(CFG_ENABLE, VAL_BITS'(1));
        write_reg(CFG_WARMUP, '0);
        write_reg(CFG_THRESHOLD, VAL_MAX);
        write_reg(CFG_MAX_RUN, VAL_BITS'(63));
        for (int b = 0; b < NUM_BRANCHES; b++)
            send_item(CMD_RESID, 2'(b), '0, '0);
        send_item(CMD_PLAN, 2'd0, 10'd5, '0);
        // product saturates on the second beat
        send_item(CMD_PLAN, 2'd1, 10'd5, VAL_MAX);
        send_item(CMD_PLAN, 2'd1, 10'd6, VAL_MAX);
        send_item(CMD_PLAN, 2'd2, 10'd5, ONE_VAL);
        // 0.5 times one LSB lands exactly on a half and rounds up
        send_item(CMD_PLAN, 2'd3, 10'd5, ONE_VAL >> 1);
        send_item(CMD_PLAN, 2'd3, 10'd6, VAL_BITS'(1));
        send_item(CMD_PLAN, 2'd3, 10'd7, VAL_BITS'(1));
    endtask

    task automatic test_limits();
        write_reg(CFG_WARMUP, '1);
        write_reg(CFG_THRESHOLD, '0);
        write_reg(CFG_MAX_RUN, VAL_BITS'(1));
        send_item(CMD_PLAN, 2'd2, 10'd1022, ONE_VAL);
        send_item(CMD_PLAN, 2'd2, 10'd1023, ONE_VAL);
        send_item(CMD_PLAN, 2'd2, 10'd1023, ONE_VAL);
        send_item(CMD_PLAN, 2'd2, 10'd1023, ONE_VAL + 1'b1);
        write_reg(CFG_MAX_RUN, '0);
        send_item(CMD_PLAN, 2'd2, 10'd1023, ONE_VAL);
        // residual capture is ignored while disabled
        send_item(CMD_CLEAR, 2'd0, '0, '0);
        write_reg(CFG_ENABLE, '0);
        send_item(CMD_RESID, 2'd1, '0, '0);
        write_reg(CFG_ENABLE, VAL_BITS'(1));
        write_reg(CFG_MAX_RUN, VAL_BITS'(63));
        send_item(CMD_PLAN, 2'd1, 10'd1023, ONE_VAL);
    endtask

    task automatic test_random();
        int                   roll;
        int                   spread;
        int                   offset;
        logic [1:0]           op;
        logic [1:0]           b;
        logic [STEP_BITS-1:0] s;
        logic [VAL_BITS-1:0]  r;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 0)
            begin
                write_reg(CFG_WARMUP, '0);
                write_reg(CFG_THRESHOLD, VAL_MAX);
                write_reg(CFG_MAX_RUN, VAL_BITS'(63));
            end
            else if (p == 1)
            begin
                write_reg(CFG_THRESHOLD, '0);
                write_reg(CFG_MAX_RUN, '0);
            end
            else
            begin
                write_reg(CFG_ENABLE, ($urandom_range(0, 7) != 0) ?
                          VAL_BITS'(1) : VAL_BITS'(0));
                write_reg(CFG_WARMUP, ($urandom_range(0, 3) == 0) ?
                          VAL_BITS'($urandom) : VAL_BITS'($urandom_range(0, 40)));
                write_reg(CFG_THRESHOLD, ($urandom_range(0, 3) == 0) ? VAL_BITS'($urandom) :
                          VAL_BITS'($urandom_range(0, 1 << $urandom_range(8, 18))));
                write_reg(CFG_MAX_RUN, ($urandom_range(0, 3) == 0) ?
                          VAL_BITS'($urandom) : VAL_BITS'($urandom_range(1, 12)));
            end
            case ($urandom_range(0, 3))
                0:       spread = 16;
                1:       spread = 512;
                2:       spread = 8192;
                default: spread = 65535;
            endcase
            sender_gaps = (p % 3 != 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                roll = $urandom_range(0, 99);
                b    = 2'($urandom_range(0, 3));
                s    = STEP_BITS'($urandom);
                r    = VAL_BITS'($urandom);
                if (roll < 72)
                begin
                    // denoising-like sequence: rising step, ratio near 1.0
                    op          = CMD_PLAN;
                    step_ctr[b] = step_ctr[b] + STEP_BITS'($urandom_range(0, 3));
                    s           = step_ctr[b];
                    offset      = $urandom_range(0, 2 * spread) - spread;
                    r           = VAL_BITS'(int'(ONE_VAL) + offset);
                end
                else if (roll < 82)
                    op = CMD_RESID;
                else if (roll < 86)
                    op = CMD_CLEAR;
                else if (roll < 88)
                    op = CMD_UNUSED;
                else
                    op = CMD_PLAN;
                if ($urandom_range(0, 299) == 0)
                    wait_idle();
                send_item(op, b, s, r);
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        decision_t want;
        if (rst_n && done)
        begin
            if (pending_decisions.size() == 0)
            begin
                $display("%0t: result with none expected: skip %0d run_length %0d",
                         $time, skip, run_length);
                mismatch_count++;
            end
            else
            begin
                want = pending_decisions.pop_front();
                if (skip !== want.skip)
                begin
                    $display("%0t: skip expected %0d actual %0d", $time, want.skip, skip);
                    mismatch_count++;
                end
                if (run_length !== want.run)
                begin
                    $display("%0t: run_length expected %0d actual %0d",
                             $time, want.run, run_length);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, pending_decisions.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = CMD_PLAN;
        branch_id      = '0;
        step_num       = '0;
        step_ratio     = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_ENABLE;
        cfg_data       = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        sender_gaps    = 1'b1;
        cfg_enable     = 1'b0;
        cfg_warmup     = '0;
        cfg_threshold  = '0;
        cfg_max_run    = '0;
        clear_table();
        for (int b = 0; b < NUM_BRANCHES; b++)
            step_ctr[b] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_disabled();
        test_skip_path();
        test_limits();
        test_random();
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
